FILE: rtl/pstc_pkg.sv
// Package for the pausable scaled time counter.
// Operation codes, controller states, field widths and the controller/datapath structs.
// No dependencies.
package pstc_pkg;

    localparam int TICK_W    = 63;
    localparam int TIME_W    = 64;
    localparam int SCALE_W   = 16;
    localparam int OP_W      = 3;
    localparam int DIV_STEPS = 63;
    localparam int CNT_W     = 6;
    localparam int S_DATA_W  = 144;

    typedef enum logic [OP_W-1:0] {
        OP_READ_TICKS = 3'd0,
        OP_READ_CLOCK = 3'd1,
        OP_ENABLE     = 3'd2,
        OP_DISABLE    = 3'd3,
        OP_SET_SCALE  = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_EVAL,
        ST_EXEC,
        ST_DIV,
        ST_FIN,
        ST_PUSH
    } t_state;

    typedef struct packed {
        logic load;
        logic prep;
        logic eval;
        logic exec;
        logic div_init;
        logic div_step;
        logic div_finish;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic need_div;
        logic div_done;
    } t_dp_stat;

endpackage

FILE: rtl/pstc_dp.sv
// Datapath of the pausable scaled time counter: time state, staged adders,
// radix-2 divider by the scale factor, result and output registers.
// Depends on pstc_pkg.
module pstc_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pstc_pkg::t_dp_cmd            i_cmd,
    output pstc_pkg::t_dp_stat           o_stat,
    input  logic [pstc_pkg::OP_W-1:0]    i_operation,
    input  logic [pstc_pkg::TICK_W-1:0]  i_host_ticks,
    input  logic [pstc_pkg::TICK_W-1:0]  i_host_clock,
    input  logic [pstc_pkg::SCALE_W-1:0] i_new_scale,
    output logic [pstc_pkg::TIME_W-1:0]  o_time_value,
    output logic                         o_order_error
);

    // captured item
    pstc_pkg::t_op                r_op;
    logic [pstc_pkg::TIME_W-1:0]  r_ticks;
    logic [pstc_pkg::TIME_W-1:0]  r_clk;
    logic [pstc_pkg::SCALE_W-1:0] r_new_scale;

    // architectural state
    logic                         r_running;
    logic [pstc_pkg::TIME_W-1:0]  r_last_ticks;
    logic [pstc_pkg::TIME_W-1:0]  r_tick_off;
    logic [pstc_pkg::TIME_W-1:0]  r_clk_off;
    logic [pstc_pkg::SCALE_W-1:0] r_scale;
    logic [pstc_pkg::TIME_W-1:0]  r_last_raw;
    logic [pstc_pkg::TIME_W-1:0]  r_last_scaled;

    // staged intermediates
    logic [pstc_pkg::TIME_W-1:0]  r_cur;
    logic [pstc_pkg::TIME_W-1:0]  r_tdiff;
    logic                         r_back;
    logic [pstc_pkg::TIME_W-1:0]  r_elapsed;
    logic [pstc_pkg::TIME_W-1:0]  r_toff_new;

    // divider
    logic [pstc_pkg::DIV_STEPS-1:0] r_quo;
    logic [pstc_pkg::SCALE_W-1:0]   r_rem;
    logic [pstc_pkg::CNT_W-1:0]     r_cnt;

    // result and output
    logic [pstc_pkg::TIME_W-1:0]  r_res_value;
    logic                         r_res_err;
    logic [pstc_pkg::TIME_W-1:0]  r_out_value;
    logic                         r_out_err;

    logic                         scaled;
    logic                         elapsed_pos;
    logic                         need_div;
    logic [pstc_pkg::TIME_W-1:0]  tick_val;
    logic [pstc_pkg::TIME_W-1:0]  clk_val;
    logic                         clk_err;
    logic [pstc_pkg::SCALE_W:0]   rem_sh;
    logic                         rem_ge;
    logic [pstc_pkg::SCALE_W:0]   rem_sub;
    logic [pstc_pkg::TIME_W-1:0]  div_result;
    logic [pstc_pkg::SCALE_W-1:0] scale_in;

    assign scaled      = (r_scale > pstc_pkg::SCALE_W'(1));
    assign elapsed_pos = !r_elapsed[pstc_pkg::TIME_W-1] && (r_elapsed != '0);
    assign need_div    = ((r_op == pstc_pkg::OP_READ_CLOCK) || (r_op == pstc_pkg::OP_DISABLE))
                         && r_running && scaled && elapsed_pos;
    assign tick_val    = r_running ? (r_ticks + r_toff_new) : r_tick_off;

    always_comb begin
        clk_err = 1'b0;
        if (!r_running) begin
            clk_val = scaled ? r_last_scaled : r_clk_off;
        end else if (!scaled) begin
            clk_val = r_cur;
        end else begin
            clk_val = r_last_scaled;
            clk_err = !elapsed_pos;
        end
    end

    assign rem_sh     = {r_rem, r_quo[pstc_pkg::DIV_STEPS-1]};
    assign rem_ge     = (rem_sh >= {1'b0, r_scale});
    assign rem_sub    = rem_sh - {1'b0, r_scale};
    assign div_result = r_last_scaled + {1'b0, r_quo};
    assign scale_in   = (r_new_scale == '0) ? pstc_pkg::SCALE_W'(1) : r_new_scale;

    assign o_stat.need_div = need_div;
    assign o_stat.div_done = (r_cnt == pstc_pkg::CNT_W'(pstc_pkg::DIV_STEPS - 1));

    // item capture, stages, divider and output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op        <= pstc_pkg::t_op'(i_operation);
            r_ticks     <= {1'b0, i_host_ticks};
            r_clk       <= {1'b0, i_host_clock};
            r_new_scale <= i_new_scale;
        end
        if (i_cmd.prep) begin
            r_cur   <= r_clk + r_clk_off;
            r_tdiff <= r_last_ticks - r_ticks;
            r_back  <= (r_last_ticks > r_ticks);
        end
        if (i_cmd.eval) begin
            r_elapsed  <= r_cur - r_last_raw;
            r_toff_new <= r_back ? (r_tick_off + r_tdiff) : r_tick_off;
        end
        if (i_cmd.div_init) begin
            r_quo <= r_elapsed[pstc_pkg::DIV_STEPS-1:0];
            r_rem <= '0;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[pstc_pkg::DIV_STEPS-2:0], rem_ge};
            r_rem <= rem_ge ? rem_sub[pstc_pkg::SCALE_W-1:0] : rem_sh[pstc_pkg::SCALE_W-1:0];
            r_cnt <= r_cnt + pstc_pkg::CNT_W'(1);
        end
        if (i_cmd.out_load) begin
            r_out_value <= r_res_value;
            r_out_err   <= r_res_err;
        end
    end

    // time state and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running     <= 1'b0;
            r_last_ticks  <= '0;
            r_tick_off    <= '0;
            r_clk_off     <= '0;
            r_scale       <= pstc_pkg::SCALE_W'(1);
            r_last_raw    <= '0;
            r_last_scaled <= '0;
            r_res_value   <= '0;
            r_res_err     <= 1'b0;
        end else if (i_cmd.exec) begin
            r_res_value <= '0;
            r_res_err   <= 1'b0;
            case (r_op)
                pstc_pkg::OP_READ_TICKS: begin
                    r_res_value <= tick_val;
                    if (r_running) begin
                        r_tick_off   <= r_toff_new;
                        r_last_ticks <= r_ticks;
                    end
                end
                pstc_pkg::OP_READ_CLOCK: begin
                    if (!need_div) begin
                        r_res_value <= clk_val;
                        r_res_err   <= clk_err;
                    end
                end
                pstc_pkg::OP_ENABLE: begin
                    if (!r_running) begin
                        r_tick_off <= r_tick_off - r_ticks;
                        r_clk_off  <= r_clk_off - r_clk;
                        r_running  <= 1'b1;
                        if (scaled) begin
                            r_last_raw    <= r_clk_off;
                            r_last_scaled <= r_clk_off;
                        end
                    end
                end
                pstc_pkg::OP_DISABLE: begin
                    if (r_running) begin
                        r_tick_off   <= tick_val;
                        r_last_ticks <= r_ticks;
                        if (!need_div) begin
                            r_clk_off <= clk_val;
                            r_running <= 1'b0;
                            r_res_err <= clk_err;
                        end
                    end
                end
                pstc_pkg::OP_SET_SCALE: begin
                    if (!scaled) begin
                        r_last_raw    <= clk_val;
                        r_last_scaled <= clk_val;
                    end
                    r_scale <= scale_in;
                end
                default: begin
                end
            endcase
        end else if (i_cmd.div_finish) begin
            r_last_scaled <= div_result;
            r_last_raw    <= r_cur;
            r_res_err     <= 1'b0;
            if (r_op == pstc_pkg::OP_DISABLE) begin
                r_clk_off   <= div_result;
                r_running   <= 1'b0;
                r_res_value <= '0;
            end else begin
                r_res_value <= div_result;
            end
        end
    end

    assign o_time_value  = r_out_value;
    assign o_order_error = r_out_err;

endmodule

FILE: rtl/pstc_ctrl.sv
// Controller of the pausable scaled time counter: sequences capture, staged
// evaluation, the divide loop and the output beat. Depends on pstc_pkg.
module pstc_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    input  pstc_pkg::t_dp_stat       i_stat,
    output pstc_pkg::t_dp_cmd        o_cmd
);

    pstc_pkg::t_state r_state;
    pstc_pkg::t_state n_state;
    logic             r_m_valid;
    logic             n_m_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pstc_pkg::ST_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_m_valid = r_m_valid && !i_m_tready;
        o_cmd     = '0;
        case (r_state)
            pstc_pkg::ST_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = pstc_pkg::ST_PREP;
                end
            end
            pstc_pkg::ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = pstc_pkg::ST_EVAL;
            end
            pstc_pkg::ST_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = pstc_pkg::ST_EXEC;
            end
            pstc_pkg::ST_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_stat.need_div) begin
                    o_cmd.div_init = 1'b1;
                    n_state        = pstc_pkg::ST_DIV;
                end else begin
                    n_state = pstc_pkg::ST_PUSH;
                end
            end
            pstc_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_done) begin
                    n_state = pstc_pkg::ST_FIN;
                end
            end
            pstc_pkg::ST_FIN: begin
                o_cmd.div_finish = 1'b1;
                n_state          = pstc_pkg::ST_PUSH;
            end
            pstc_pkg::ST_PUSH: begin
                if (!r_m_valid || i_m_tready) begin
                    o_cmd.out_load = 1'b1;
                    n_m_valid      = 1'b1;
                    n_state        = pstc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pstc_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_s_tready = (r_state == pstc_pkg::ST_IDLE);
    assign o_m_tvalid = r_m_valid;

endmodule

FILE: rtl/pausable_scaled_time_counter_core.sv
// Pausable scaled time counter, top level: stream ports around controller and datapath.
// Depends on pstc_pkg, pstc_ctrl and pstc_dp.
//
// Usage: each input beat carries an operation (read ticks, read clock, enable,
// disable, set scale) in tuser and fresh host tick and host clock samples plus a
// new scale in tdata. Every input beat yields exactly one output beat: the time
// value in tdata and the order error flag in tuser.
// Each item passes the prep, eval and exec states to the output beat, and a
// scaled clock evaluation also runs the divider (63 radix-2 steps of elapsed time by
// the 16-bit scale). One item is in flight at a time: the next input beat is taken
// only once the current result has moved to the output register.
// A finished result sits in the output register while the next item is taken;
// a later result waits in the datapath result register until that register is
// free, so a stalled receiver holds the output beat stable and eventually blocks input.
// Reset (synchronous, active low): counter stopped, all offsets and last values
// zero, scale one, no output pending.
module pausable_scaled_time_counter_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // [62:0] host_ticks, [125:63] host_clock, [141:126] new_scale, [143:142] zero
    input  logic [pstc_pkg::S_DATA_W-1:0]  i_s_tdata,
    // [2:0] operation
    input  logic [pstc_pkg::OP_W-1:0]      i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [63:0] time_value
    output logic [pstc_pkg::TIME_W-1:0]    o_m_tdata,
    // [0] order_error
    output logic                           o_m_tuser
);

    pstc_pkg::t_dp_cmd  cmd;
    pstc_pkg::t_dp_stat stat;

    pstc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pstc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_operation   (i_s_tuser),
        .i_host_ticks  (i_s_tdata[62:0]),
        .i_host_clock  (i_s_tdata[125:63]),
        .i_new_scale   (i_s_tdata[141:126]),
        .o_time_value  (o_m_tdata),
        .o_order_error (o_m_tuser)
    );

endmodule

FILE: tb/pstc_time_checker.sv
`timescale 1ns / 100ps
// Checker for the pausable scaled time counter: watches both stream channels,
// predicts each result from the accepted input beats and compares them in order.
// Depends on pstc_pkg.
module pstc_time_checker
    import pstc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    input  logic                i_s_tready,
    // [62:0] host_ticks, [125:63] host_clock, [141:126] new_scale, [143:142] zero
    input  logic [S_DATA_W-1:0] i_s_tdata,
    // [2:0] operation
    input  logic [OP_W-1:0]     i_s_tuser,
    input  logic                i_m_tvalid,
    input  logic                i_m_tready,
    // [63:0] time_value
    input  logic [TIME_W-1:0]   i_m_tdata,
    // [0] order_error
    input  logic                i_m_tuser,
    output int                  o_pending,
    output int                  o_errors
);

    typedef struct packed {
        logic [TIME_W-1:0] time_value;
        logic              order_error;
    } t_time_result;

    t_time_result expected_times[$];
    int           mismatches = 0;

    logic               running;
    logic [TIME_W-1:0]  last_host_ticks;
    logic [TIME_W-1:0]  tick_offset;
    logic [TIME_W-1:0]  clock_offset;
    logic [SCALE_W-1:0] scale_factor;
    logic [TIME_W-1:0]  last_raw_clock;
    logic [TIME_W-1:0]  last_scaled_clock;
    logic               order_fault;

    assign o_errors = mismatches;

    function automatic logic [TIME_W-1:0] guest_ticks(input logic [TICK_W-1:0] ticks);
        logic [TIME_W-1:0] t64;
        t64 = {1'b0, ticks};
        if (!running)
            return tick_offset;
        // host counter went backwards: fold the step into the offset
        if ($signed(last_host_ticks) > $signed(t64))
            tick_offset = tick_offset + (last_host_ticks - t64);
        last_host_ticks = t64;
        return t64 + tick_offset;
    endfunction

    function automatic logic [TIME_W-1:0] guest_clock(input logic [TICK_W-1:0] clk);
        logic [TIME_W-1:0] cur;
        logic [TIME_W-1:0] elapsed;
        if (!running)
            return (scale_factor > 16'd1) ? last_scaled_clock : clock_offset;
        cur = {1'b0, clk} + clock_offset;
        if (scale_factor <= 16'd1)
            return cur;
        elapsed = cur - last_raw_clock;
        if (elapsed[TIME_W-1] || elapsed == '0) begin
            order_fault = 1'b1;
            return last_scaled_clock;
        end
        last_scaled_clock = last_scaled_clock
                          + elapsed / {{(TIME_W-SCALE_W){1'b0}}, scale_factor};
        last_raw_clock = cur;
        return last_scaled_clock;
    endfunction

    function automatic t_time_result next_time_result(
        input logic [OP_W-1:0]    op,
        input logic [TICK_W-1:0]  ticks,
        input logic [TICK_W-1:0]  clk,
        input logic [SCALE_W-1:0] scale
    );
        t_time_result res;
        res = '0;
        order_fault = 1'b0;
        case (op)
            OP_READ_TICKS: begin
                res.time_value = guest_ticks(ticks);
            end
            OP_READ_CLOCK: begin
                res.time_value = guest_clock(clk);
            end
            OP_ENABLE: begin
                if (!running) begin
                    tick_offset  = tick_offset - {1'b0, ticks};
                    clock_offset = clock_offset - {1'b0, clk};
                    running      = 1'b1;
                    if (scale_factor > 16'd1) begin
                        last_raw_clock    = {1'b0, clk} + clock_offset;
                        last_scaled_clock = last_raw_clock;
                    end
                end
            end
            OP_DISABLE: begin
                if (running) begin
                    tick_offset  = guest_ticks(ticks);
                    clock_offset = guest_clock(clk);
                    running      = 1'b0;
                end
            end
            OP_SET_SCALE: begin
                if (scale_factor == 16'd1) begin
                    last_raw_clock    = guest_clock(clk);
                    last_scaled_clock = last_raw_clock;
                end
                scale_factor = (scale == '0) ? 16'd1 : scale;
            end
            default: begin
            end
        endcase
        res.order_error = order_fault;
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_time_result got;
        t_time_result want;
        if (!i_rst_n) begin
            running           = 1'b0;
            last_host_ticks   = '0;
            tick_offset       = '0;
            clock_offset      = '0;
            scale_factor      = 16'd1;
            last_raw_clock    = '0;
            last_scaled_clock = '0;
            expected_times.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.time_value  = i_m_tdata;
                got.order_error = i_m_tuser;
                if (expected_times.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result beat: time_value %h order_error %b",
                                 $time, got.time_value, got.order_error);
                end else begin
                    want = expected_times.pop_front();
                    if (got.time_value !== want.time_value
                        || got.order_error !== want.order_error) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: mismatch: time_value exp %h got %h, ",
                                      "order_error exp %b got %b"}, $time,
                                     want.time_value, got.time_value,
                                     want.order_error, got.order_error);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                expected_times.push_back(next_time_result(
                    i_s_tuser,
                    i_s_tdata[TICK_W-1:0],
                    i_s_tdata[2*TICK_W-1:TICK_W],
                    i_s_tdata[2*TICK_W+SCALE_W-1:2*TICK_W]));
        end
        o_pending <= expected_times.size();
    end

endmodule

FILE: tb/pausable_scaled_time_counter_core_tb.sv
`timescale 1ns / 100ps
// Testbench top for pausable_scaled_time_counter_core: clock, reset, directed and
// random operation beats, random output backpressure and the verdict.
// Depends on pstc_pkg, pausable_scaled_time_counter_core and pstc_time_checker.
module pausable_scaled_time_counter_core_tb;
    import pstc_pkg::*;

    localparam logic [OP_W-1:0]   OP_SPARE_A   = 3'd5;
    localparam logic [OP_W-1:0]   OP_SPARE_B   = 3'd6;
    localparam logic [OP_W-1:0]   OP_SPARE_C   = 3'd7;
    localparam logic [TICK_W-1:0] TICK_MAX     = '1;
    localparam int                RANDOM_BEATS = 1130;
    localparam int                DRAIN_CYCLES = 80;
    localparam int                LONG_HOLD    = 400;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [OP_W-1:0]     s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [TIME_W-1:0]   m_tdata;
    logic                m_tuser;
    int                  pending;
    int                  errors;

    logic [TICK_W-1:0]   host_ticks_now;
    logic [TICK_W-1:0]   host_clock_now;
    bit                  tx_burst;

    always #5 clk = ~clk;

    pausable_scaled_time_counter_core dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    pstc_time_checker time_check (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .i_m_tuser  (m_tuser),
        .o_pending  (pending),
        .o_errors   (errors)
    );

    // called at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_item(
        input logic [OP_W-1:0]    op,
        input logic [TICK_W-1:0]  ticks,
        input logic [TICK_W-1:0]  clock,
        input logic [SCALE_W-1:0] scale
    );
        int gap;
        gap = tx_burst ? 0 : int'($urandom_range(0, 5));
        repeat (gap) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, scale, clock, ticks};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // mostly forward steps, some backward steps, a few arbitrary jumps
    function automatic logic [TICK_W-1:0] next_sample(input logic [TICK_W-1:0] now);
        int unsigned pick;
        logic [63:0] rnd;
        pick = $urandom_range(0, 99);
        rnd  = {$urandom, $urandom};
        if (pick < 3)
            return rnd[TICK_W-1:0];
        if (pick < 10)
            return now - TICK_W'($urandom_range(0, 5000));
        return now + TICK_W'($urandom_range(0, 200000));
    endfunction

    function automatic logic [OP_W-1:0] pick_op();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 28)
            return OP_READ_TICKS;
        if (pick < 60)
            return OP_READ_CLOCK;
        if (pick < 72)
            return OP_ENABLE;
        if (pick < 84)
            return OP_DISABLE;
        if (pick < 96)
            return OP_SET_SCALE;
        return OP_W'($urandom_range(OP_SPARE_C, OP_SPARE_A));
    endfunction

    function automatic logic [SCALE_W-1:0] pick_scale();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            return SCALE_W'($urandom_range(1, 8));
        if (pick < 8)
            return SCALE_W'($urandom_range(0, 65535));
        return SCALE_W'($urandom_range(0, 1));
    endfunction

    initial begin : stimulus
        int n;
        host_ticks_now = '0;
        host_clock_now = '0;
        tx_burst       = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_item(OP_READ_TICKS, TICK_MAX, TICK_MAX, 16'hFFFF);
        send_item(OP_READ_CLOCK, TICK_MAX, TICK_MAX, 16'h0000);
        send_item(OP_DISABLE,    63'd5, 63'd5, 16'd1);
        send_item(OP_SET_SCALE,  63'd0, 63'd0, 16'd0);
        send_item(OP_ENABLE,     63'd100, 63'd1000, 16'd1);
        send_item(OP_ENABLE,     63'd200, 63'd2000, 16'd1);
        send_item(OP_READ_TICKS, 63'd150, 63'd0, 16'd1);
        send_item(OP_READ_TICKS, 63'd120, 63'd0, 16'd1);
        send_item(OP_READ_CLOCK, 63'd0, 63'd2500, 16'd1);
        send_item(OP_SET_SCALE,  63'd0, 63'd3000, 16'hFFFF);
        send_item(OP_READ_CLOCK, 63'd0, 63'd461745, 16'd1);
        send_item(OP_READ_CLOCK, 63'd0, 63'd461745, 16'd1);
        send_item(OP_READ_CLOCK, 63'd0, 63'd400000, 16'd1);
        send_item(OP_SET_SCALE,  63'd0, 63'd0, 16'd3);
        send_item(OP_READ_CLOCK, 63'd0, TICK_MAX, 16'd1);
        send_item(OP_DISABLE,    63'd300, 63'd0, 16'd1);
        send_item(OP_READ_CLOCK, 63'd0, 63'd0, 16'd1);
        send_item(OP_READ_TICKS, 63'd0, 63'd0, 16'd1);
        send_item(OP_SPARE_A,    TICK_MAX, TICK_MAX, 16'hFFFF);
        send_item(OP_SPARE_B,    TICK_MAX, TICK_MAX, 16'hFFFF);
        send_item(OP_SPARE_C,    TICK_MAX, TICK_MAX, 16'hFFFF);
        send_item(OP_SET_SCALE,  63'd0, 63'd0, 16'd1);
        send_item(OP_ENABLE,     TICK_MAX, TICK_MAX, 16'd1);
        send_item(OP_READ_TICKS, 63'd0, 63'd0, 16'd1);
        send_item(OP_DISABLE,    TICK_MAX, 63'd0, 16'd1);

        for (n = 0; n < RANDOM_BEATS; n++) begin
            if (n % 200 == 100)
                tx_burst = ~tx_burst;
            host_ticks_now = next_sample(host_ticks_now);
            host_clock_now = next_sample(host_clock_now);
            send_item(pick_op(), host_ticks_now, host_clock_now, pick_scale());
        end
        s_tvalid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("pausable_scaled_time_counter_core_tb: done, clean");
        else
            $display("pausable_scaled_time_counter_core_tb: done, errors");
        $finish;
    end

    // output side: random stalls per beat, one long hold to back up the input
    initial begin : receiver
        int rx_wait;
        int rx_beats;
        bit rx_burst;
        rx_wait  = 0;
        rx_beats = 0;
        rx_burst = 1'b0;
        wait (rst_n);
        forever begin
            @(posedge clk);
            if (m_tvalid && m_tready) begin
                rx_beats++;
                if (rx_beats % 150 == 0)
                    rx_burst = ~rx_burst;
                if (rx_beats == 300)
                    rx_wait = LONG_HOLD;
                else
                    rx_wait = rx_burst ? 0 : int'($urandom_range(0, 5));
            end
            @(negedge clk);
            if (rx_wait > 0) begin
                m_tready <= 1'b0;
                rx_wait--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        #5_000_000;
        $display("pausable_scaled_time_counter_core_tb: done, errors");
        $finish;
    end

endmodule

FILE: sim.f
rtl/pstc_pkg.sv
rtl/pstc_dp.sv
rtl/pstc_ctrl.sv
rtl/pausable_scaled_time_counter_core.sv
tb/pstc_time_checker.sv
tb/pausable_scaled_time_counter_core_tb.sv
